// ===== design/assert_macros.svh =====
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge once reset has been released.
`define GDA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds once reset has been released.
`define GDA_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  `GDA_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

// ===== design/gda_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package gda_pkg;

  localparam int unsigned TableDepth = 64;
  localparam int unsigned KeyBits    = 24;
  localparam int unsigned IdxW       = $clog2(TableDepth);
  localparam int unsigned UsedW      = $clog2(TableDepth + 1);
  localparam int unsigned QDepth     = 2;
  localparam int unsigned QPtrW      = $clog2(QDepth);
  localparam int unsigned QCntW      = $clog2(QDepth + 1);

  localparam int unsigned CmdW   = 2;
  localparam int unsigned KeyW   = 24;
  localparam int unsigned CntW   = 32;
  localparam int unsigned TotW   = 48;
  localparam int unsigned DurW   = 40;
  localparam int unsigned EvW    = 24;
  localparam int unsigned ShareW = 16;
  localparam int unsigned DivW   = 62;
  localparam int unsigned DivCntW = $clog2(DivW);

  localparam logic [KeyW-1:0] KeyMask = KeyW'((64'd1 << KeyBits) - 64'd1);

  localparam logic [CmdW-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CmdW-1:0] CMD_ADD   = 2'd1;
  localparam logic [CmdW-1:0] CMD_READ  = 2'd2;

  localparam logic REG_PARENT = 1'b0;

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_ADD,
    OP_READ
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_RO_RD,
    S_RO_WAIT,
    S_MEAN_DIV,
    S_MULT,
    S_MULT2,
    S_SHARE_DIV,
    S_EMIT,
    S_EMPTY
  } back_state_e;

  typedef struct packed {
    op_e             op;
    logic [KeyW-1:0] key;
    logic [DurW-1:0] dur;
    logic [EvW-1:0]  ev;
  } item_t;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [CntW-1:0] cnt;
    logic [TotW-1:0] total;
    logic [DurW-1:0] minv;
    logic [DurW-1:0] maxv;
    logic [EvW-1:0]  longest;
  } entry_t;

  typedef struct packed {
    logic              group_valid;
    logic [KeyW-1:0]   group_name;
    logic [CntW-1:0]   record_count;
    logic [TotW-1:0]   total_time;
    logic [DurW-1:0]   mean_time;
    logic [DurW-1:0]   least_time;
    logic [DurW-1:0]   greatest_time;
    logic [EvW-1:0]    longest_event;
    logic [ShareW-1:0] share_hundredths;
    logic              overflow_seen;
    logic              last_of_run;
  } result_t;

  typedef struct packed {
    logic            start;
    logic [DivW-1:0] dividend;
    logic [DurW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic [DivW-1:0] quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

// ===== design/gda_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module gda_front import gda_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire logic [CmdW-1:0] command_i,
  input  wire logic [KeyW-1:0] name_id_i,
  input  wire logic [DurW-1:0] duration_i,
  input  wire logic [EvW-1:0]  event_index_i,
  output logic                 head_valid_o,
  output item_t                head_o,
  input  wire logic            pop_i
);

  item_t             q_q [QDepth];
  logic [QPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0]  cnt_q;
  logic              keep;
  op_e               op;
  logic              push, pop;

  // classify the command; the unused code is taken and dropped
  always_comb begin
    keep = 1'b1;
    op   = OP_CLEAR;
    unique case (command_i)
      CMD_CLEAR: op = OP_CLEAR;
      CMD_ADD:   op = OP_ADD;
      CMD_READ:  op = OP_READ;
      default:   keep = 1'b0;
    endcase
  end

  assign in_stall_o   = (cnt_q == QCntW'(QDepth));
  assign push         = in_valid_i && !in_stall_o && keep;
  assign pop          = pop_i && (cnt_q != '0);
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = q_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push && !pop)      cnt_q <= cnt_q + 1'b1;
      else if (pop && !push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wr_ptr_q] <= '{op: op, key: name_id_i & KeyMask, dur: duration_i, ev: event_index_i};
    end
  end

endmodule
`default_nettype wire

// ===== design/gda_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module gda_div import gda_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  div_req_t  req_i,
  output div_rsp_t  rsp_o
);

  logic [DivW-1:0]    quo_q;
  logic [DurW-1:0]    rem_q, dsr_q;
  logic [DivCntW-1:0] cnt_q;
  logic               busy_q, done_q;
  logic [DurW:0]      trial, diff;
  logic               ge;

  // restoring division, one quotient bit a cycle
  assign trial = {rem_q, quo_q[DivW-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign ge    = (trial >= {1'b0, dsr_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DivCntW'(DivW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      dsr_q <= req_i.divisor;
    end else if (busy_q) begin
      quo_q <= {quo_q[DivW-2:0], ge};
      rem_q <= ge ? diff[DurW-1:0] : trial[DurW-1:0];
    end
  end

  assign rsp_o = '{busy: busy_q, done: done_q, quotient: quo_q};

endmodule
`default_nettype wire

// ===== design/gda_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module gda_back import gda_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            head_valid_i,
  input  item_t                head_i,
  output logic                 pop_o,
  input  wire logic [DurW-1:0] parent_i,
  output div_req_t             div_req_o,
  input  div_rsp_t             div_rsp_i,
  output logic                 out_valid_o,
  output result_t              out_o,
  input  wire logic            out_stall_i
);

  back_state_e       state_q, state_d;
  logic [UsedW-1:0]  idx_q, used_q;
  logic              ovf_q;
  entry_t            mem [TableDepth];
  entry_t            rd_q, ent_q, upd, fresh, wr_data;
  logic              wr_en;
  logic [IdxW-1:0]   wr_addr;
  logic [DurW-1:0]   mean_q, base;
  logic [ShareW-1:0] share_q;
  logic [DivW-1:0]   prod_q;
  result_t           out_q;
  logic              out_valid_q;
  logic              hit, last, full, slot_free, empty_tab;
  logic [TotW:0]     sum;

  assign hit       = (rd_q.key == head_i.key);
  assign last      = ((idx_q + 1'b1) == used_q);
  assign full      = (used_q == UsedW'(TableDepth));
  assign empty_tab = (used_q == '0);
  assign slot_free = !out_valid_q || !out_stall_i;
  assign base      = (parent_i == '0) ? DurW'(1) : parent_i;

  // update of a matching group, saturating count and total
  always_comb begin
    upd = rd_q;
    sum = {1'b0, rd_q.total} + (TotW + 1)'(head_i.dur);
    if (rd_q.cnt != '1) upd.cnt = rd_q.cnt + 1'b1;
    upd.total = sum[TotW] ? '1 : sum[TotW-1:0];
    if (head_i.dur < rd_q.minv) upd.minv = head_i.dur;
    if (head_i.dur > rd_q.maxv) begin
      upd.maxv    = head_i.dur;
      upd.longest = head_i.ev;
    end
  end

  assign fresh = '{key: head_i.key, cnt: CntW'(1), total: TotW'(head_i.dur),
                   minv: head_i.dur, maxv: head_i.dur, longest: head_i.ev};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (head_valid_i) begin
          unique case (head_i.op)
            OP_ADD:  state_d = empty_tab ? S_IDLE : S_SCAN_RD;
            OP_READ: state_d = empty_tab ? S_EMPTY : S_RO_RD;
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_SCAN_RD:   state_d = S_SCAN_CMP;
      S_SCAN_CMP:  state_d = (hit || last) ? S_IDLE : S_SCAN_RD;
      S_RO_RD:     state_d = S_RO_WAIT;
      S_RO_WAIT:   state_d = S_MEAN_DIV;
      S_MEAN_DIV:  if (div_rsp_i.done) state_d = S_MULT;
      S_MULT:      state_d = S_MULT2;
      S_MULT2:     state_d = S_SHARE_DIV;
      S_SHARE_DIV: if (div_rsp_i.done) state_d = S_EMIT;
      S_EMIT:      if (slot_free) state_d = last ? S_IDLE : S_RO_RD;
      S_EMPTY:     if (slot_free) state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  always_comb begin
    pop_o     = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = idx_q[IdxW-1:0];
    wr_data   = upd;
    div_req_o = '{start: 1'b0, dividend: DivW'(ent_q.total), divisor: base};
    unique case (state_q)
      S_IDLE: begin
        if (head_valid_i) begin
          unique case (head_i.op)
            OP_CLEAR: pop_o = 1'b1;
            OP_ADD: begin
              if (empty_tab) begin
                pop_o   = 1'b1;
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_data = fresh;
              end
            end
            default: pop_o = 1'b0;
          endcase
        end
      end
      S_SCAN_CMP: begin
        if (hit) begin
          pop_o = 1'b1;
          wr_en = 1'b1;
        end else if (last) begin
          pop_o   = 1'b1;
          wr_en   = !full;
          wr_addr = used_q[IdxW-1:0];
          wr_data = fresh;
        end
      end
      S_RO_WAIT: begin
        div_req_o = '{start: 1'b1, dividend: DivW'(rd_q.total), divisor: DurW'(rd_q.cnt)};
      end
      S_MULT2: begin
        div_req_o = '{start: 1'b1,
                      dividend: prod_q + (DivW'(ent_q.total) << 8) + (DivW'(ent_q.total) << 4),
                      divisor: base};
      end
      S_EMIT:  pop_o = slot_free && last;
      S_EMPTY: pop_o = slot_free;
      default: pop_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_q <= mem[idx_q[IdxW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      used_q      <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        S_IDLE: begin
          idx_q <= '0;
          if (head_valid_i && head_i.op == OP_CLEAR) begin
            used_q <= '0;
            ovf_q  <= 1'b0;
          end else if (head_valid_i && head_i.op == OP_ADD && empty_tab) begin
            used_q <= UsedW'(1);
          end
        end
        S_SCAN_CMP: begin
          if (!hit) begin
            if (!last)     idx_q  <= idx_q + 1'b1;
            else if (full) ovf_q  <= 1'b1;
            else           used_q <= used_q + 1'b1;
          end
        end
        S_EMIT:  if (slot_free) idx_q <= idx_q + 1'b1;
        default: idx_q <= idx_q;
      endcase
      if (slot_free && (state_q == S_EMIT || state_q == S_EMPTY)) out_valid_q <= 1'b1;
      else if (!out_stall_i)                                      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_RO_WAIT) ent_q <= rd_q;
    if (state_q == S_MEAN_DIV && div_rsp_i.done) begin
      mean_q <= (div_rsp_i.quotient[DivW-1:DurW] != '0) ? '1 : div_rsp_i.quotient[DurW-1:0];
    end
    if (state_q == S_MULT) begin
      prod_q <= (DivW'(ent_q.total) << 13) + (DivW'(ent_q.total) << 10)
              + (DivW'(ent_q.total) << 9);
    end
    if (state_q == S_SHARE_DIV && div_rsp_i.done) begin
      share_q <= (div_rsp_i.quotient[DivW-1:ShareW] != '0) ? '1
               : div_rsp_i.quotient[ShareW-1:0];
    end
    if (state_q == S_EMIT && slot_free) begin
      out_q <= '{group_valid: 1'b1, group_name: ent_q.key, record_count: ent_q.cnt,
                 total_time: ent_q.total, mean_time: mean_q, least_time: ent_q.minv,
                 greatest_time: ent_q.maxv, longest_event: ent_q.longest,
                 share_hundredths: share_q, overflow_seen: ovf_q, last_of_run: last};
    end else if (state_q == S_EMPTY && slot_free) begin
      out_q <= '{group_valid: 1'b0, group_name: '0, record_count: '0,
                 total_time: '0, mean_time: '0, least_time: '0,
                 greatest_time: '0, longest_event: '0,
                 share_hundredths: '0, overflow_seen: ovf_q, last_of_run: 1'b1};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `GDA_ASSERT(a_used_bound, clk_i, rst_ni, used_q <= UsedW'(TableDepth), "group count beyond table")
  `GDA_ASSERT_NEVER(a_div_busy, clk_i, rst_ni, div_req_o.start && div_rsp_i.busy, "divider restarted")
  `GDA_ASSERT(a_wr_room, clk_i, rst_ni, wr_en |-> ({1'b0, wr_addr} < used_q) || !full, "append when full")

endmodule
`default_nettype wire

// ===== design/group_duration_aggregator_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel   Handshake                Direction  Carries
// in        in_valid_i / in_stall_o  inbound    command, name_id, duration, event_index
// out       out_valid_o / out_stall_i outbound  one group statistics record
// cfg       psel/penable/pwrite      inbound    parent_duration at byte address 0
//
// Command 3 is taken and dropped at the input; a clear is popped from the front
// queue straight from idle; an add to a non-empty table scans it with a read
// state and a compare state per stored group (one memory read port). Readout
// runs the shared bit-serial divider twice per group (mean, then share) and
// waits in S_EMIT while the output is stalled; an empty table returns its single
// record with group_valid low. Reset is asynchronous, active low; the table
// needs no clearing pass. A two-entry queue keeps accepting transactions until
// full while the back end works or a finished record waits on out_stall_i.
module group_duration_aggregator_core import gda_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire logic [CmdW-1:0] command_i,
  input  wire logic [KeyW-1:0] name_id_i,
  input  wire logic [DurW-1:0] duration_i,
  input  wire logic [EvW-1:0]  event_index_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output logic                 group_valid_o,
  output logic [KeyW-1:0]      group_name_o,
  output logic [CntW-1:0]      record_count_o,
  output logic [TotW-1:0]      total_time_o,
  output logic [DurW-1:0]      mean_time_o,
  output logic [DurW-1:0]      least_time_o,
  output logic [DurW-1:0]      greatest_time_o,
  output logic [EvW-1:0]       longest_event_o,
  output logic [ShareW-1:0]    share_hundredths_o,
  output logic                 overflow_seen_o,
  output logic                 last_of_run_o,
  input  wire logic            psel,
  input  wire logic            penable,
  input  wire logic            pwrite,
  input  wire logic [3:0]      paddr,
  input  wire logic [63:0]     pwdata,
  output logic [63:0]          prdata,
  output logic                 pready
);

  logic [DurW-1:0] parent_q;
  logic            head_valid, pop;
  item_t           head;
  div_req_t        div_req;
  div_rsp_t        div_rsp;
  result_t         res;

  // hold the parent duration; only register slot zero exists
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parent_q <= DurW'(1);
    end else if (psel && penable && pwrite && paddr[3] == REG_PARENT) begin
      parent_q <= pwdata[DurW-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[3] == REG_PARENT) ? 64'(parent_q) : '0;

  gda_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .command_i, .name_id_i,
    .duration_i, .event_index_i,
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  gda_div u_div (
    .clk_i, .rst_ni,
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  gda_back u_back (
    .clk_i, .rst_ni,
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .parent_i     (parent_q),
    .div_req_o    (div_req),
    .div_rsp_i    (div_rsp),
    .out_valid_o,
    .out_o        (res),
    .out_stall_i
  );

  assign group_valid_o      = res.group_valid;
  assign group_name_o       = res.group_name;
  assign record_count_o     = res.record_count;
  assign total_time_o       = res.total_time;
  assign mean_time_o        = res.mean_time;
  assign least_time_o       = res.least_time;
  assign greatest_time_o    = res.greatest_time;
  assign longest_event_o    = res.longest_event;
  assign share_hundredths_o = res.share_hundredths;
  assign overflow_seen_o    = res.overflow_seen;
  assign last_of_run_o      = res.last_of_run;

endmodule
`default_nettype wire

// ===== test/group_duration_aggregator_core_test.sv =====
`timescale 1ns / 1ps
module group_duration_aggregator_core_test;
  import gda_pkg::*;

  // Command 3 has no meaning in the block; it must be swallowed silently.
  localparam logic [CmdW-1:0] CMD_UNUSED = 2'd3;
  // Register map: 64-bit data, so register i sits at byte address 8*i.
  localparam logic [3:0] ADDR_PARENT = 4'd0;
  localparam logic [3:0] ADDR_BEYOND = 4'd8;
  localparam logic [DurW-1:0] DUR_MAX = '1;
  localparam logic [KeyW-1:0] KEY_MAX = '1;
  localparam logic [TotW-1:0] TOT_MAX = '1;
  localparam int unsigned IDLE_LIMIT = 6000;
  localparam int unsigned SETTLE_CYCLES = 400;

  // Mirror of the group table; works out the records a readout must return.
  class group_table_model;
    logic [KeyW-1:0] keys[TableDepth];
    logic [CntW-1:0] counts[TableDepth];
    logic [TotW-1:0] totals[TableDepth];
    logic [DurW-1:0] mins[TableDepth];
    logic [DurW-1:0] maxs[TableDepth];
    logic [EvW-1:0]  longest[TableDepth];
    int unsigned     used;
    bit              overflow;
    logic [DurW-1:0] parent;
    result_t         pending[$];
    int unsigned     mismatches;
    int unsigned     records_seen;

    function new();
      used = 0;
      overflow = 0;
      parent = 1;
      mismatches = 0;
      records_seen = 0;
    endfunction

    function void set_parent(logic [3:0] addr, logic [63:0] value);
      if (addr == ADDR_PARENT) parent = value[DurW-1:0];
    endfunction

    function void merge_record(logic [KeyW-1:0] key, logic [DurW-1:0] dur,
                               logic [EvW-1:0] ev);
      logic [TotW:0] sum;
      for (int i = 0; i < used; i++) begin
        if (keys[i] == key) begin
          if (counts[i] != '1) counts[i]++;
          sum = totals[i] + dur;
          totals[i] = (sum > TOT_MAX) ? TOT_MAX : sum[TotW-1:0];
          if (dur < mins[i]) mins[i] = dur;
          if (dur > maxs[i]) begin
            maxs[i] = dur;
            longest[i] = ev;
          end
          return;
        end
      end
      if (used >= TableDepth) begin
        overflow = 1;
        return;
      end
      keys[used] = key;
      counts[used] = 1;
      totals[used] = dur;
      mins[used] = dur;
      maxs[used] = dur;
      longest[used] = ev;
      used++;
    endfunction

    // Note an accepted input transaction and queue whatever it must produce.
    function void note_transaction(logic [CmdW-1:0] cmd, logic [KeyW-1:0] key,
                                   logic [DurW-1:0] dur, logic [EvW-1:0] ev);
      result_t r;
      logic [63:0] base, share, mean;
      if (cmd == CMD_CLEAR) begin
        used = 0;
        overflow = 0;
      end else if (cmd == CMD_ADD) begin
        merge_record(key & KeyMask, dur, ev);
      end else if (cmd == CMD_READ) begin
        if (used == 0) begin
          r = '0;
          r.overflow_seen = overflow;
          r.last_of_run = 1'b1;
          pending = {pending, r};
        end
        base = (parent == 0) ? 64'd1 : 64'(parent);
        for (int i = 0; i < used; i++) begin
          share = (64'(totals[i]) * 64'd10000) / base;
          mean = 64'(totals[i]) / 64'(counts[i]);
          r.group_valid = 1'b1;
          r.group_name = keys[i];
          r.record_count = counts[i];
          r.total_time = totals[i];
          r.mean_time = (mean > 64'(DUR_MAX)) ? DUR_MAX : mean[DurW-1:0];
          r.least_time = mins[i];
          r.greatest_time = maxs[i];
          r.longest_event = longest[i];
          r.share_hundredths = (share > 64'hFFFF) ? 16'hFFFF : share[ShareW-1:0];
          r.overflow_seen = overflow;
          r.last_of_run = (i + 1 == used);
          pending = {pending, r};
        end
      end
    endfunction

    function void compare_field(string label, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, label, want, got);
      end
    endfunction

    // Check one delivered group record against the oldest outstanding one.
    function void check_record(result_t got);
      result_t want;
      records_seen++;
      if (pending.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected record, expected none, actual %0h", $realtime, got);
        return;
      end
      want = pending.pop_front();
      compare_field("group_valid", want.group_valid, got.group_valid);
      compare_field("group_name", want.group_name, got.group_name);
      compare_field("record_count", want.record_count, got.record_count);
      compare_field("total_time", want.total_time, got.total_time);
      compare_field("mean_time", want.mean_time, got.mean_time);
      compare_field("least_time", want.least_time, got.least_time);
      compare_field("greatest_time", want.greatest_time, got.greatest_time);
      compare_field("longest_event", want.longest_event, got.longest_event);
      compare_field("share_hundredths", want.share_hundredths, got.share_hundredths);
      compare_field("overflow_seen", want.overflow_seen, got.overflow_seen);
      compare_field("last_of_run", want.last_of_run, got.last_of_run);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [CmdW-1:0] command_i = CMD_CLEAR;
  logic [KeyW-1:0] name_id_i = '0;
  logic [DurW-1:0] duration_i = '0;
  logic [EvW-1:0] event_index_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  result_t got;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;

  group_table_model table_model = new();
  int unsigned items_sent = 0;
  int unsigned readouts_sent = 0;
  int unsigned reg_writes = 0;
  int unsigned idle_cycles = 0;
  bit quiet_input = 0;
  bit quiet_output = 0;
  int unsigned stall_left = 0;
  logic [KeyW-1:0] key_pool[8];

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  group_duration_aggregator_core dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .command_i, .name_id_i,
    .duration_i, .event_index_i, .out_valid_o, .out_stall_i,
    .group_valid_o(got.group_valid), .group_name_o(got.group_name),
    .record_count_o(got.record_count), .total_time_o(got.total_time),
    .mean_time_o(got.mean_time), .least_time_o(got.least_time),
    .greatest_time_o(got.greatest_time), .longest_event_o(got.longest_event),
    .share_hundredths_o(got.share_hundredths), .overflow_seen_o(got.overflow_seen),
    .last_of_run_o(got.last_of_run), .psel, .penable, .pwrite, .paddr, .pwdata,
    .prdata, .pready
  );

  // Gap length: mostly nothing or a few cycles, now and then a long pause.
  function automatic int unsigned pick_gap(bit quiet);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [DurW-1:0] pick_duration();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return DUR_MAX;
      2: return DurW'($urandom_range(0, 1000));
      default: return {8'($urandom), 32'($urandom)};
    endcase
  endfunction

  // Sink side back-pressure: stall bursts, with stretches of none at all.
  always @(posedge clk_i) begin
    if ($urandom_range(0, 199) == 0) quiet_output <= ~quiet_output;
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (!quiet_output && $urandom_range(0, 3) == 0) begin
      stall_left <= pick_gap(0);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Deliver every record leaving the block to the scoreboard.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) table_model.check_record(got);
  end

  // Watchdog: give up when neither channel has moved for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (rst_ni) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Present one transaction and hold it until the block takes it.
  task automatic push_item(logic [CmdW-1:0] cmd, logic [KeyW-1:0] key,
                           logic [DurW-1:0] dur, logic [EvW-1:0] ev);
    int unsigned gap;
    in_valid_i <= 1'b1;
    command_i <= cmd;
    name_id_i <= key;
    duration_i <= dur;
    event_index_i <= ev;
    do @(posedge clk_i); while (in_stall_o);
    table_model.note_transaction(cmd, key, dur, ev);
    if (cmd != CMD_UNUSED) items_sent++;
    if (cmd == CMD_READ) readouts_sent++;
    if ($urandom_range(0, 99) == 0) quiet_input = ~quiet_input;
    gap = pick_gap(quiet_input);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic add_record(logic [KeyW-1:0] key, logic [DurW-1:0] dur);
    push_item(CMD_ADD, key, dur, EvW'($urandom));
  endtask

  // Wait until every record is back, then let a trailing add finish its scan.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (table_model.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Setup and access phase write, then read back the parent duration.
  task automatic write_reg(logic [3:0] addr, logic [63:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    table_model.set_parent(addr, value);
    reg_writes++;
    pwrite <= 1'b0;
    penable <= 1'b0;
    paddr <= ADDR_PARENT;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[DurW-1:0] !== table_model.parent) begin
      table_model.mismatches++;
      $display("%0t: parent_duration readback mismatch, expected %0h, actual %0h",
               $realtime, table_model.parent, prdata[DurW-1:0]);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic pick_parent();
    case ($urandom_range(0, 4))
      0: write_reg(ADDR_PARENT, 64'd1);
      1: write_reg(ADDR_PARENT, 64'(DUR_MAX));
      2: write_reg(ADDR_PARENT, 64'($urandom_range(1, 100000)));
      default: write_reg(ADDR_PARENT, {24'd0, 8'($urandom), 32'($urandom)});
    endcase
  endtask

  // A session: an optional clear, adds mostly over a few keys with stray commands mixed in, then a readout.
  task automatic run_session();
    int unsigned n_keys, n_adds;
    n_keys = $urandom_range(1, 8);
    n_adds = $urandom_range(3, 25);
    for (int k = 0; k < n_keys; k++) key_pool[k] = KeyW'($urandom);
    if ($urandom_range(0, 3) != 0) push_item(CMD_CLEAR, KeyW'($urandom), '0, '0);
    for (int i = 0; i < n_adds; i++) begin
      case ($urandom_range(0, 19))
        0: push_item(CMD_UNUSED, KeyW'($urandom), pick_duration(), EvW'($urandom));
        1: push_item(CMD_READ, KeyW'($urandom), pick_duration(), EvW'($urandom));
        2: add_record(KeyW'($urandom), pick_duration());
        default: add_record(key_pool[$urandom_range(0, n_keys - 1)], pick_duration());
      endcase
    end
    push_item(CMD_READ, '0, '0, '0);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty readout, extremes, ties on the maximum, ignored command.
    write_reg(ADDR_PARENT, 64'd1);
    push_item(CMD_READ, '0, '0, '0);
    add_record('0, '0);
    push_item(CMD_ADD, KEY_MAX, DUR_MAX, '1);
    push_item(CMD_ADD, '0, DUR_MAX, EvW'(5));
    push_item(CMD_ADD, '0, DUR_MAX, EvW'(7));
    push_item(CMD_ADD, '0, DurW'(3), '0);
    push_item(CMD_ADD, KEY_MAX, '0, '0);
    push_item(CMD_UNUSED, KEY_MAX, DUR_MAX, '1);
    push_item(CMD_READ, '0, '0, '0);
    settle();
    write_reg(ADDR_PARENT, 64'(DUR_MAX));
    write_reg(ADDR_BEYOND, 64'd77);
    push_item(CMD_READ, '0, '0, '0);
    push_item(CMD_CLEAR, '0, '0, '0);
    push_item(CMD_READ, '0, '0, '0);
    settle();
    // Zero parent duration counts as one.
    write_reg(ADDR_PARENT, 64'd0);
    push_item(CMD_ADD, KeyW'(42), DurW'(123456), EvW'(9));
    push_item(CMD_ADD, KeyW'(42), DurW'(1), EvW'(10));
    push_item(CMD_READ, '0, '0, '0);
    settle();

    // Fill past the table depth: the new keys drop and overflow sticks.
    write_reg(ADDR_PARENT, 64'($urandom_range(1, 1000000)));
    push_item(CMD_CLEAR, '0, '0, '0);
    for (int i = 0; i < TableDepth + 3; i++) add_record(KeyW'(i * 977 + 3), pick_duration());
    add_record(KeyW'(3), pick_duration());
    push_item(CMD_READ, '0, '0, '0);
    run_session();
    settle();

    // Drive one group's total into saturation with maximum durations.
    write_reg(ADDR_PARENT, 64'd1);
    push_item(CMD_CLEAR, '0, '0, '0);
    for (int i = 0; i < 260; i++) push_item(CMD_ADD, KeyW'(11), DUR_MAX, EvW'(i));
    push_item(CMD_READ, '0, '0, '0);
    settle();

    while (items_sent < 470) begin
      if ($urandom_range(0, 2) == 0) begin
        settle();
        pick_parent();
      end
      run_session();
    end

    settle();
    $display("Sent %0d transactions (%0d readouts), checked %0d group records,",
             items_sent, readouts_sent, table_model.records_seen);
    $display("with %0d register writes including zero and full-scale parent durations.",
             reg_writes);
    if (table_model.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
